// ----- rtl/core/ffca_pkg.sv -----
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared constants, codes, types and helpers of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

   localparam int DEF_MAX_EXTENTS = 64;
   localparam int HEAP_BYTES      = 65536;
   localparam int ALIGN_BYTES     = 16;
   localparam int HDR_BYTES       = 16;
   localparam int ADDR_SPAN       = 65536;
   localparam int HDR_SLOTS       = ADDR_SPAN / ALIGN_BYTES;
   localparam int HDR_AW          = $clog2(HDR_SLOTS);
   localparam int LIM_CAP_INT     = (HEAP_BYTES < ADDR_SPAN) ? HEAP_BYTES : ADDR_SPAN;

   localparam logic [16:0] LIM_CAP     = 17'(LIM_CAP_INT);
   localparam logic [16:0] BYTES_MAX   = 17'h1FFFF;
   localparam logic [16:0] RST_LIMIT   = 17'd65536;
   localparam logic [16:0] RST_CHUNK   = 17'd4096;

   // response status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OOM  = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   // csr register indexes
   localparam logic CSR_HEAP_LIMIT  = 1'b0;
   localparam logic CSR_CHUNK_BYTES = 1'b1;

   typedef struct packed {
      logic [15:0] start;
      logic [16:0] bytes;
   } ext_type;

   function automatic logic [16:0] sat_bytes(input logic [18:0] v);
      return (v > {2'b00, BYTES_MAX}) ? BYTES_MAX : v[16:0];
   endfunction

endpackage

// ----- rtl/core/first_fit_coalescing_allocator_top.sv -----
// Paths: a hit scans the extents and moves later entries up; a split adds an insert; growth
//   adds an insert and a rescan; release is an insert; zero size, over-limit, null or bad
//   address go straight to the response. An insert walks and moves entries.
// Throughput: one transaction at a time; the next request can be taken while the response is
//   shown, and a finished response waits in place while the receiver stalls.
// Reset: synchronous; count, bump top to zero, registers to defaults; tables not cleared.
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_top
// First-fit free-extent allocator with sorted coalescing release and bump growth.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_top #(
   parameter int MAX_EXTENTS = ffca_pkg::DEF_MAX_EXTENTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [16:0] req_request_size,
   input  logic [15:0] req_block_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_address,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_data
);

   localparam int AW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);
   localparam logic [CW-1:0] ONE     = CW'(1);

   typedef enum logic [5:0] {
      ST_IDLE, ST_WANT, ST_WANTH, ST_SC_RD, ST_SC_CHK,
      ST_G_NEED, ST_G_MAX, ST_G_TOP, ST_G_EXACT, ST_G_FULL, ST_G_LAST, ST_G_TAKE,
      ST_D_RD, ST_D_WR, ST_SP_CHK, ST_SP_START, ST_SP_BYTES, ST_HDR_WR,
      ST_R_HDR, ST_R_SIZE,
      ST_P_INIT, ST_P_RD, ST_P_CHK, ST_P_NX, ST_P_NM, ST_P_PV, ST_P_DEC, ST_P_PW,
      ST_P_UR, ST_P_UW, ST_P_RET, ST_FIN
   } state_type;

   typedef enum logic [1:0] {RET_REL, RET_GROW, RET_SPLIT} ret_type;

   state_type   state_ff;
   ret_type     ret_ff;
   logic [16:0] cfg_limit_ff, cfg_chunk_ff;
   logic [CW-1:0] count_ff, idx_ff, sh_ff;
   logic [16:0] bump_ff;
   logic [16:0] raw_ff, want_ff, n_ff, hdrv_ff;
   logic [17:0] wanth_ff, need_ff;
   logic [15:0] s_ff, addr_ff;
   logic [ffca_pkg::HDR_AW-1:0] ahdr_ff;
   logic [1:0]  status_ff;
   logic        pass_ff, have_prev_ff, have_next_ff, nxt_ff, prv_ff, put_ok_ff;
   logic        drop_put_ff;
   ffca_pkg::ext_type prev_ff, next_ff, ext_rd_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [15:0] rsp_address_ff;
   logic [16:0] hdr_rd_ff;

   // memories
   ffca_pkg::ext_type ext_mem [MAX_EXTENTS];
   logic [16:0]       hdr_mem [ffca_pkg::HDR_SLOTS];

   logic [AW-1:0]     ext_raddr, ext_waddr;
   logic              ext_we, hdr_we;
   ffca_pkg::ext_type ext_wdata;

   // shared adder
   logic [18:0] alu_a, alu_b, alu_res;
   logic [4:0]  alu_k;
   logic [16:0] lim_w;

   assign alu_res   = alu_a + alu_b + 19'(alu_k);
   assign lim_w     = (cfg_limit_ff > ffca_pkg::LIM_CAP) ? ffca_pkg::LIM_CAP : cfg_limit_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_address = rsp_address_ff;

   always_comb begin
      ext_raddr = '0;
      ext_waddr = '0;
      ext_we    = 1'b0;
      ext_wdata = '{start: s_ff, bytes: n_ff};
      hdr_we    = 1'b0;
      alu_a     = '0;
      alu_b     = '0;
      alu_k     = '0;
      case (state_ff)
         ST_WANT: begin
            alu_a = 19'(raw_ff);
            alu_k = 5'd15;
         end
         ST_WANTH: begin
            alu_a = 19'(want_ff);
            alu_k = 5'd16;
         end
         ST_SC_RD: ext_raddr = idx_ff[AW-1:0];
         ST_G_NEED: begin
            alu_a = 19'(cfg_chunk_ff);
            alu_k = 5'd15;
         end
         ST_G_TOP, ST_G_TAKE: begin
            alu_a = 19'(bump_ff);
            alu_b = 19'(need_ff);
         end
         ST_G_EXACT: begin
            alu_a = 19'(bump_ff);
            alu_b = 19'(wanth_ff);
         end
         ST_G_FULL: ext_raddr = AW'(count_ff - ONE);
         ST_G_LAST: begin
            alu_a = 19'(ext_rd_ff.start);
            alu_b = 19'(ext_rd_ff.bytes);
            alu_k = 5'd16;
         end
         ST_D_RD: ext_raddr = AW'(idx_ff + ONE);
         ST_D_WR: begin
            ext_we    = 1'b1;
            ext_waddr = idx_ff[AW-1:0];
            ext_wdata = ext_rd_ff;
         end
         ST_SP_CHK: begin
            alu_a = 19'(wanth_ff);
            alu_k = 5'd16;
         end
         ST_SP_START: begin
            alu_a = 19'(s_ff);
            alu_b = 19'(wanth_ff);
         end
         ST_SP_BYTES: begin
            alu_a = 19'(n_ff);
            alu_b = ~19'(wanth_ff);
            alu_k = 5'd1;
         end
         ST_HDR_WR: hdr_we = 1'b1;
         ST_P_RD: ext_raddr = idx_ff[AW-1:0];
         ST_P_NX: begin
            alu_a = 19'(s_ff);
            alu_b = 19'(n_ff);
            alu_k = 5'd16;
         end
         ST_P_NM: begin
            alu_a = 19'(n_ff);
            alu_b = 19'(next_ff.bytes);
            alu_k = 5'd16;
         end
         ST_P_PV: begin
            alu_a = 19'(prev_ff.start);
            alu_b = 19'(prev_ff.bytes);
            alu_k = 5'd16;
         end
         ST_P_DEC: begin
            if (!prv_ff && nxt_ff) begin
               ext_we    = 1'b1;
               ext_waddr = idx_ff[AW-1:0];
            end
         end
         ST_P_PW: begin
            alu_a     = 19'(prev_ff.bytes);
            alu_b     = 19'(n_ff);
            alu_k     = 5'd16;
            ext_we    = 1'b1;
            ext_waddr = AW'(idx_ff - ONE);
            ext_wdata = '{start: prev_ff.start, bytes: ffca_pkg::sat_bytes(alu_res)};
         end
         ST_P_UR: begin
            if (sh_ff == idx_ff) begin
               ext_we    = 1'b1;
               ext_waddr = idx_ff[AW-1:0];
            end else begin
               ext_raddr = AW'(sh_ff - ONE);
            end
         end
         ST_P_UW: begin
            ext_we    = 1'b1;
            ext_waddr = sh_ff[AW-1:0];
            ext_wdata = ext_rd_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ext_we) begin
         ext_mem[ext_waddr] <= ext_wdata;
      end
      ext_rd_ff <= ext_mem[ext_raddr];
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_mem[ahdr_ff] <= hdrv_ff;
      end
      hdr_rd_ff <= hdr_mem[s_ff[15:4]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_limit_ff <= ffca_pkg::RST_LIMIT;
         cfg_chunk_ff <= ffca_pkg::RST_CHUNK;
         count_ff     <= '0;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               ffca_pkg::CSR_HEAP_LIMIT:  cfg_limit_ff <= csr_data;
               ffca_pkg::CSR_CHUNK_BYTES: cfg_chunk_ff <= csr_data;
               default: ;
            endcase
         end
         // in finish the response register is reloaded instead
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  raw_ff    <= req_request_size;
                  s_ff      <= {req_block_address[15:4] - 12'd1, 4'b0000};
                  addr_ff   <= '0;
                  status_ff <= ffca_pkg::ST_OK;
                  pass_ff   <= 1'b0;
                  if (!req_mode) begin
                     if (req_request_size == '0) begin
                        status_ff <= ffca_pkg::ST_ZERO;
                        state_ff  <= ST_FIN;
                     end else if (req_request_size > lim_w) begin
                        status_ff <= ffca_pkg::ST_OOM;
                        state_ff  <= ST_FIN;
                     end else begin
                        state_ff <= ST_WANT;
                     end
                  end else if (req_block_address == '0 || req_block_address[3:0] != '0 ||
                               {1'b0, req_block_address} > bump_ff) begin
                     state_ff <= ST_FIN;
                  end else begin
                     state_ff <= ST_R_HDR;
                  end
               end
            end
            ST_WANT: begin
               want_ff  <= alu_res[16:0] & ~17'hF;
               state_ff <= ST_WANTH;
            end
            ST_WANTH: begin
               wanth_ff <= alu_res[17:0];
               idx_ff   <= '0;
               state_ff <= ST_SC_RD;
            end
            ST_SC_RD: begin
               if (idx_ff == count_ff) begin
                  if (pass_ff) begin
                     status_ff <= ffca_pkg::ST_OOM;
                     state_ff  <= ST_FIN;
                  end else begin
                     state_ff <= ST_G_NEED;
                  end
               end else begin
                  state_ff <= ST_SC_CHK;
               end
            end
            ST_SC_CHK: begin
               if (ext_rd_ff.bytes >= want_ff) begin
                  s_ff        <= ext_rd_ff.start;
                  n_ff        <= ext_rd_ff.bytes;
                  hdrv_ff     <= ext_rd_ff.bytes;
                  ahdr_ff     <= ext_rd_ff.start[15:4];
                  addr_ff     <= ext_rd_ff.start + 16'd16;
                  drop_put_ff <= 1'b0;
                  state_ff    <= ST_D_RD;
               end else begin
                  idx_ff   <= idx_ff + ONE;
                  state_ff <= ST_SC_RD;
               end
            end
            ST_G_NEED: begin
               need_ff  <= alu_res[17:0] & ~18'hF;
               state_ff <= ST_G_MAX;
            end
            ST_G_MAX: begin
               if (need_ff < wanth_ff) begin
                  need_ff <= wanth_ff;
               end
               state_ff <= ST_G_TOP;
            end
            ST_G_TOP: begin
               if (alu_res > 19'(lim_w)) begin
                  need_ff  <= wanth_ff;
                  state_ff <= ST_G_EXACT;
               end else begin
                  state_ff <= ST_G_FULL;
               end
            end
            ST_G_EXACT: begin
               if (alu_res > 19'(lim_w)) begin
                  status_ff <= ffca_pkg::ST_OOM;
                  state_ff  <= ST_FIN;
               end else begin
                  state_ff <= ST_G_FULL;
               end
            end
            ST_G_FULL: begin
               state_ff <= (count_ff >= CNT_MAX) ? ST_G_LAST : ST_G_TAKE;
            end
            ST_G_LAST: begin
               // full table: growth must merge into the highest extent
               if (alu_res != 19'(bump_ff)) begin
                  status_ff <= ffca_pkg::ST_FULL;
                  state_ff  <= ST_FIN;
               end else begin
                  state_ff <= ST_G_TAKE;
               end
            end
            ST_G_TAKE: begin
               s_ff     <= bump_ff[15:0];
               n_ff     <= 17'(need_ff - 18'd16);
               bump_ff  <= alu_res[16:0];
               ret_ff   <= RET_GROW;
               state_ff <= ST_P_INIT;
            end
            ST_D_RD: begin
               if (idx_ff + ONE >= count_ff) begin
                  count_ff <= count_ff - ONE;
                  if (drop_put_ff) begin
                     put_ok_ff <= 1'b1;
                     state_ff  <= ST_P_RET;
                  end else begin
                     state_ff <= ST_SP_CHK;
                  end
               end else begin
                  state_ff <= ST_D_WR;
               end
            end
            ST_D_WR: begin
               idx_ff   <= idx_ff + ONE;
               state_ff <= ST_D_RD;
            end
            ST_SP_CHK: begin
               if ({2'b00, n_ff} >= alu_res) begin
                  hdrv_ff  <= want_ff;
                  state_ff <= ST_SP_START;
               end else begin
                  state_ff <= ST_HDR_WR;
               end
            end
            ST_SP_START: begin
               s_ff     <= alu_res[15:0];
               state_ff <= ST_SP_BYTES;
            end
            ST_SP_BYTES: begin
               n_ff     <= alu_res[16:0];
               ret_ff   <= RET_SPLIT;
               state_ff <= ST_P_INIT;
            end
            ST_HDR_WR: begin
               status_ff <= ffca_pkg::ST_OK;
               state_ff  <= ST_FIN;
            end
            ST_R_HDR: state_ff <= ST_R_SIZE;
            ST_R_SIZE: begin
               n_ff     <= hdr_rd_ff;
               ret_ff   <= RET_REL;
               state_ff <= ST_P_INIT;
            end
            ST_P_INIT: begin
               idx_ff       <= '0;
               have_prev_ff <= 1'b0;
               state_ff     <= ST_P_RD;
            end
            ST_P_RD: begin
               if (idx_ff == count_ff) begin
                  have_next_ff <= 1'b0;
                  state_ff     <= ST_P_NX;
               end else begin
                  state_ff <= ST_P_CHK;
               end
            end
            ST_P_CHK: begin
               if (ext_rd_ff.start < s_ff) begin
                  prev_ff      <= ext_rd_ff;
                  have_prev_ff <= 1'b1;
                  idx_ff       <= idx_ff + ONE;
                  state_ff     <= ST_P_RD;
               end else begin
                  next_ff      <= ext_rd_ff;
                  have_next_ff <= 1'b1;
                  state_ff     <= ST_P_NX;
               end
            end
            ST_P_NX: begin
               nxt_ff   <= have_next_ff && (alu_res == 19'(next_ff.start));
               state_ff <= ST_P_NM;
            end
            ST_P_NM: begin
               if (nxt_ff) begin
                  n_ff <= ffca_pkg::sat_bytes(alu_res);
               end
               state_ff <= ST_P_PV;
            end
            ST_P_PV: begin
               prv_ff   <= have_prev_ff && (alu_res == 19'(s_ff));
               state_ff <= ST_P_DEC;
            end
            ST_P_DEC: begin
               if (prv_ff) begin
                  state_ff <= ST_P_PW;
               end else if (nxt_ff) begin
                  put_ok_ff <= 1'b1;
                  state_ff  <= ST_P_RET;
               end else if (count_ff >= CNT_MAX) begin
                  put_ok_ff <= 1'b0;
                  state_ff  <= ST_P_RET;
               end else begin
                  sh_ff    <= count_ff;
                  state_ff <= ST_P_UR;
               end
            end
            ST_P_PW: begin
               if (nxt_ff) begin
                  // both neighbors touch: the following extent is absorbed
                  drop_put_ff <= 1'b1;
                  state_ff    <= ST_D_RD;
               end else begin
                  put_ok_ff <= 1'b1;
                  state_ff  <= ST_P_RET;
               end
            end
            ST_P_UR: begin
               if (sh_ff == idx_ff) begin
                  count_ff  <= count_ff + ONE;
                  put_ok_ff <= 1'b1;
                  state_ff  <= ST_P_RET;
               end else begin
                  state_ff <= ST_P_UW;
               end
            end
            ST_P_UW: begin
               sh_ff    <= sh_ff - ONE;
               state_ff <= ST_P_UR;
            end
            ST_P_RET: begin
               case (ret_ff)
                  RET_REL: begin
                     status_ff <= put_ok_ff ? ffca_pkg::ST_OK : ffca_pkg::ST_FULL;
                     state_ff  <= ST_FIN;
                  end
                  RET_GROW: begin
                     pass_ff  <= 1'b1;
                     idx_ff   <= '0;
                     state_ff <= ST_SC_RD;
                  end
                  RET_SPLIT: state_ff <= ST_HDR_WR;
                  default:   state_ff <= ST_FIN;
               endcase
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= status_ff;
                  rsp_address_ff <= addr_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("extent count above table depth");

   a_bump_bound: assert property (@(posedge clock) disable iff (reset)
      bump_ff <= ffca_pkg::LIM_CAP)
      else $error("bump top beyond heap");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready while a transaction is in work");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ext_we && !hdr_we)
      else $error("memory write while idle");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("response raised outside finish");
`endif

endmodule
